>>> hw/rtl/glyph_atlas_shelf_allocator_assert.svh
// Assertion macros for the glyph atlas shelf allocator checker.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_ASSERT_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define GASA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph atlas assertion failed");

// Next-cycle implication.
`define GASA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph atlas assertion failed");

`endif

>>> hw/rtl/gasa_pkg.sv
// Shared types and constants for the glyph atlas shelf allocator.
// No dependencies.
package gasa_pkg;

  localparam int GLYPH_PAD   = 2;
  localparam int ID_W        = 16;
  localparam int DIM_W       = 8;
  localparam int PAD_DIM_W   = 9;   // glyph size plus border
  localparam int SLOT_IDX_W  = 6;
  localparam int POS_W       = 9;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_PLACE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROW,
    ST_ROW_ADV,
    ST_TOP,
    ST_TOP_RD,
    ST_TOP_CHK,
    ST_SHELF,
    ST_BASE,
    ST_BOTTOM,
    ST_SH_RD,
    ST_SH_LO,
    ST_SH_HI,
    ST_RING,
    ST_RING_EV,
    ST_PLACE_X,
    ST_PLACE,
    ST_ADVANCE
  } gasa_state_t;

endpackage

>>> hw/rtl/gasa_alu.sv
// Shared add-and-compare unit: sum = a + b, gt = sum > c.
// No dependencies.
module gasa_alu #(
  parameter int W = 11
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] c,
  output logic [W:0]   sum,
  output logic         gt
);

  assign sum = {1'b0, a} + {1'b0, b};
  assign gt  = sum > {1'b0, c};

endmodule

>>> hw/rtl/gasa_slot_ram.sv
// Slot ring storage: one write port, one registered read port.
// No dependencies.
module gasa_slot_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 27
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/glyph_atlas_shelf_allocator.sv
// Glyph atlas shelf allocator, top level: sequencer, state and output register.
// Depends on gasa_pkg, gasa_alu and gasa_slot_ram.

// Each request places one glyph, with a one-pixel border, in a shelf-packed
// atlas and records it in a ring of SLOTS slots (at most SLOTS-1 live). The
// block answers with zero or more eviction items (kind 0: slot and glyph id
// freed, positions zero) followed by one placement item (kind 1, tlast set,
// interior x/y). A request flagged already resident gives nothing, and the
// input is ready again in the next cycle. Other requests step through the
// row, top, shelf and ring tests, placement and cursor advance. A row wrap
// adds a step for the new shelf; an atlas-top wrap adds a read and a check,
// and another read and check per eviction; a taller shelf adds the base and
// bottom steps and a walk of reads and row tests, an eviction per pass; a
// ring-full eviction adds an eviction step. The sequencer waits while the
// output register is full and not being emptied. The steps follow from the
// single shared adder/comparator taking the wrap, shelf and placement tests
// one per cycle while the output register can take items, and from the one
// read port of the slot memory, always addressed at the oldest slot and
// registered, so a read state precedes each row test. Input is not ready
// while a request is in progress. Result items sit in an output register so
// the sequencer carries on as soon as the register is free or being emptied.
// The slot memory has no reset: only slots inside the ring are ever read.
module glyph_atlas_shelf_allocator
  import gasa_pkg::*;
#(
  parameter int ATLAS_WIDTH  = 512,
  parameter int ATLAS_HEIGHT = 512,
  parameter int SLOTS        = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // glyph_id[15:0], glyph_width[23:16], glyph_height[31:24]
  input  logic [0:0]  s_axis_tuser,   // already_resident[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // slot_index[5:0], slot_glyph[21:6], pos_x[30:22], pos_y[39:31]
  output logic [0:0]  m_axis_tuser,   // kind[0]
  output logic        m_axis_tlast    // last
);

  // Coordinate width: covers the atlas plus one overhanging shelf and glyph.
  localparam int ADIM = (ATLAS_WIDTH > ATLAS_HEIGHT) ? ATLAS_WIDTH : ATLAS_HEIGHT;
  localparam int CW   = $clog2(ADIM + 1024);
  localparam int SW   = $clog2(SLOTS);
  localparam int DW   = CW + ID_W;

  localparam logic [CW-1:0] ATLAS_W_C = CW'(ATLAS_WIDTH);
  localparam logic [CW-1:0] ATLAS_H_C = CW'(ATLAS_HEIGHT);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

  function automatic logic [SW-1:0] ring_inc(input logic [SW-1:0] i);
    ring_inc = (i == SLOT_LAST) ? '0 : i + 1'b1;
  endfunction

  gasa_state_t state, state_next;

  // Packing state
  logic [CW-1:0] cursor_x, cursor_x_next;
  logic [CW-1:0] cursor_y, cursor_y_next;
  logic [CW-1:0] shelf_height, shelf_height_next;
  logic [SW-1:0] oldest_slot, oldest_slot_next;
  logic [SW-1:0] next_slot, next_slot_next;

  // Request and scratch
  logic [ID_W-1:0]      req_id;
  logic [PAD_DIM_W-1:0] req_wp, req_hp;
  logic [CW-1:0]        base, base_next;
  logic [CW-1:0]        bottom, bottom_next;
  logic [POS_W-1:0]     px, px_next;

  // Shared unit
  logic [CW-1:0] alu_a, alu_b, alu_c;
  logic [CW:0]   alu_sum;
  logic          alu_gt;

  // Slot memory
  logic            ram_we;
  logic [DW-1:0]   ram_wdata, ram_rdata;
  logic [CW-1:0]   rd_row;
  logic [ID_W-1:0] rd_owner;

  // Output
  logic                  can_emit, emit;
  logic                  emit_kind, emit_last;
  logic [SLOT_IDX_W-1:0] emit_slot;
  logic [ID_W-1:0]       emit_glyph;
  logic [POS_W-1:0]      emit_px, emit_py;

  logic ring_empty, ring_full, accept;

  gasa_alu #(.W(CW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  gasa_slot_ram #(.DEPTH(SLOTS), .AW(SW), .DW(DW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_slot),
    .wdata (ram_wdata),
    .raddr (oldest_slot),
    .rdata (ram_rdata)
  );

  assign rd_row   = ram_rdata[DW-1:ID_W];
  assign rd_owner = ram_rdata[ID_W-1:0];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !m_axis_tvalid || m_axis_tready;
  assign ring_empty    = (oldest_slot == next_slot);
  assign ring_full     = (ring_inc(next_slot) == oldest_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    shelf_height_next = shelf_height;
    oldest_slot_next  = oldest_slot;
    next_slot_next    = next_slot;
    base_next         = base;
    bottom_next       = bottom;
    px_next           = px;
    alu_a             = cursor_x;
    alu_b             = '0;
    alu_c             = '0;
    ram_we            = 1'b0;
    ram_wdata         = {alu_sum[CW-1:0], req_id};
    emit              = 1'b0;
    emit_kind         = KIND_EVICT;
    emit_last         = 1'b0;
    emit_slot         = SLOT_IDX_W'(oldest_slot);
    emit_glyph        = rd_owner;
    emit_px           = '0;
    emit_py           = '0;

    case (state)
      ST_IDLE: begin
        if (accept && !s_axis_tuser[0]) begin
          state_next = ST_ROW;
        end
      end
      // Row wrap test: cursor_x + w + 2 > width
      ST_ROW: begin
        alu_a = cursor_x;
        alu_b = CW'(req_wp);
        alu_c = ATLAS_W_C;
        state_next = alu_gt ? ST_ROW_ADV : ST_TOP;
      end
      ST_ROW_ADV: begin
        alu_a             = cursor_y;
        alu_b             = shelf_height;
        cursor_y_next     = alu_sum[CW-1:0];
        cursor_x_next     = '0;
        shelf_height_next = '0;
        state_next        = ST_TOP;
      end
      // Top wrap test: cursor_y + h + 2 > height
      ST_TOP: begin
        alu_a = cursor_y;
        alu_b = CW'(req_hp);
        alu_c = ATLAS_H_C;
        if (alu_gt) begin
          cursor_x_next     = '0;
          cursor_y_next     = '0;
          shelf_height_next = '0;
          state_next        = ST_TOP_RD;
        end else begin
          state_next = ST_SHELF;
        end
      end
      ST_TOP_RD: begin
        state_next = ring_empty ? ST_SHELF : ST_TOP_CHK;
      end
      // Evict while the oldest row is nonzero
      ST_TOP_CHK: begin
        alu_a = rd_row;
        if (alu_gt) begin
          if (can_emit) begin
            emit             = 1'b1;
            oldest_slot_next = ring_inc(oldest_slot);
            state_next       = ST_TOP_RD;
          end
        end else begin
          state_next = ST_SHELF;
        end
      end
      // Taller shelf unless shelf_height > h + 2
      ST_SHELF: begin
        alu_a = shelf_height;
        alu_c = CW'(req_hp);
        state_next = alu_gt ? ST_RING : ST_BASE;
      end
      ST_BASE: begin
        alu_a      = cursor_y;
        alu_b      = shelf_height;
        base_next  = alu_sum[CW-1:0];
        state_next = ST_BOTTOM;
      end
      ST_BOTTOM: begin
        alu_a             = cursor_y;
        alu_b             = CW'(req_hp);
        bottom_next       = alu_sum[CW-1:0];
        shelf_height_next = CW'(req_hp);
        state_next        = ST_SH_RD;
      end
      ST_SH_RD: begin
        state_next = ring_empty ? ST_RING : ST_SH_LO;
      end
      // row < base ends the walk
      ST_SH_LO: begin
        alu_a = base;
        alu_c = rd_row;
        state_next = alu_gt ? ST_RING : ST_SH_HI;
      end
      // row >= bottom, as row + 1 > bottom, ends the walk
      ST_SH_HI: begin
        alu_a = rd_row;
        alu_b = CW'(1);
        alu_c = bottom;
        if (alu_gt) begin
          state_next = ST_RING;
        end else if (can_emit) begin
          emit             = 1'b1;
          oldest_slot_next = ring_inc(oldest_slot);
          state_next       = ST_SH_RD;
        end
      end
      // Doubles as the read cycle for a ring-full eviction
      ST_RING: begin
        state_next = ring_full ? ST_RING_EV : ST_PLACE_X;
      end
      ST_RING_EV: begin
        if (can_emit) begin
          emit             = 1'b1;
          oldest_slot_next = ring_inc(oldest_slot);
          state_next       = ST_PLACE_X;
        end
      end
      ST_PLACE_X: begin
        alu_a      = cursor_x;
        alu_b      = CW'(1);
        px_next    = alu_sum[POS_W-1:0];
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        alu_a = cursor_y;
        alu_b = CW'(1);
        if (can_emit) begin
          ram_we         = 1'b1;
          emit           = 1'b1;
          emit_kind      = KIND_PLACE;
          emit_last      = 1'b1;
          emit_slot      = SLOT_IDX_W'(next_slot);
          emit_glyph     = req_id;
          emit_px        = px;
          emit_py        = alu_sum[POS_W-1:0];
          next_slot_next = ring_inc(next_slot);
          state_next     = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        alu_a         = cursor_x;
        alu_b         = CW'(req_wp);
        cursor_x_next = alu_sum[CW-1:0];
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x      <= '0;
      cursor_y      <= '0;
      shelf_height  <= '0;
      oldest_slot   <= '0;
      next_slot     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      shelf_height <= shelf_height_next;
      oldest_slot  <= oldest_slot_next;
      next_slot    <= next_slot_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk) begin
    base   <= base_next;
    bottom <= bottom_next;
    px     <= px_next;
    if (accept) begin
      req_id <= s_axis_tdata[15:0];
      req_wp <= PAD_DIM_W'(s_axis_tdata[23:16]) + PAD_DIM_W'(GLYPH_PAD);
      req_hp <= PAD_DIM_W'(s_axis_tdata[31:24]) + PAD_DIM_W'(GLYPH_PAD);
    end
    if (emit) begin
      m_axis_tdata <= {emit_py, emit_px, emit_glyph, emit_slot};
      m_axis_tuser <= emit_kind;
      m_axis_tlast <= emit_last;
    end
  end

endmodule

>>> hw/rtl/gasa_checker.sv
// Port-level checker for the glyph atlas shelf allocator, bound to the top.
// Depends on glyph_atlas_shelf_allocator_assert.svh.
`include "glyph_atlas_shelf_allocator_assert.svh"

module gasa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled item holds
  `GASA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  // placement is always the final item of a request, evictions never are
  `GASA_ASSERT_IMP(a_kind_last, m_axis_tvalid, m_axis_tuser[0] == m_axis_tlast)
  // evictions carry no position
  `GASA_ASSERT_IMP(a_evict_nopos, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[39:22] == 18'd0)
  // a resident glyph is skipped without a busy period
  `GASA_ASSERT_NXT(a_resident_skip, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], s_axis_tready)

endmodule

bind glyph_atlas_shelf_allocator gasa_checker u_gasa_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for glyph_atlas_shelf_allocator: a predictor of the
// shelf packer and slot ring, bursty stimulus and a stalling result sink.
// Depends on gasa_pkg and the glyph_atlas_shelf_allocator RTL.
module testbench;
  import gasa_pkg::*;

  localparam int ATLAS_W        = 512;
  localparam int ATLAS_H        = 512;
  localparam int NUM_SLOTS      = 64;
  localparam int RANDOM_GLYPHS  = 209;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  // One glyph request; hold makes the sender wait until every result is in.
  typedef struct {
    logic [ID_W-1:0]  id;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             resident;
    bit               hold;
  } glyph_req_t;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_IDX_W-1:0] slot;
    logic [ID_W-1:0]       glyph;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic                  last;
  } atlas_result_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_STALL} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  glyph_atlas_shelf_allocator #(
    .ATLAS_WIDTH (ATLAS_W),
    .ATLAS_HEIGHT(ATLAS_H),
    .SLOTS       (NUM_SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Atlas predictor: packing cursor, shelf and slot ring mirrored at item
  // acceptance; every result it foresees goes onto pending_results.
  // ---------------------------------------------------------------------------
  int unsigned   pack_x, pack_y, shelf_h;
  int unsigned   ring_head, ring_tail;        // oldest slot, next free slot
  int unsigned   owner_of [NUM_SLOTS];
  int unsigned   row_of   [NUM_SLOTS];
  atlas_result_t pending_results [$];
  int            error_count;

  task automatic evict_oldest();
    atlas_result_t r;
    r.kind  = KIND_EVICT;
    r.slot  = SLOT_IDX_W'(ring_head);
    r.glyph = ID_W'(owner_of[ring_head]);
    r.pos_x = '0;
    r.pos_y = '0;
    r.last  = 1'b0;
    pending_results.push_back(r);
    ring_head = (ring_head + 1) % NUM_SLOTS;
  endtask

  task automatic place_glyph(glyph_req_t g);
    int unsigned   w, h, base_row, bottom_row;
    atlas_result_t r;
    w = g.width;
    h = g.height;
    if (g.resident)
      return;
    // row full: start a new shelf under the current one
    if (w + pack_x + GLYPH_PAD > ATLAS_W) begin
      pack_x  = 0;
      pack_y += shelf_h;
      shelf_h = 0;
    end
    // off the bottom: back to the top, dropping every slot with a live row
    if (h + pack_y + GLYPH_PAD > ATLAS_H) begin
      pack_x  = 0;
      pack_y  = 0;
      shelf_h = 0;
      while (ring_head != ring_tail && row_of[ring_head] > 0)
        evict_oldest();
    end
    // shelf grows: free whatever sits in the band it now covers
    if (h + GLYPH_PAD >= shelf_h) begin
      base_row   = pack_y + shelf_h;
      bottom_row = pack_y + h + GLYPH_PAD;
      while (ring_head != ring_tail) begin
        if (row_of[ring_head] < base_row || row_of[ring_head] >= bottom_row)
          break;
        evict_oldest();
      end
      shelf_h = h + GLYPH_PAD;
    end
    // one slot always stays empty in the ring
    if ((ring_tail + 1) % NUM_SLOTS == ring_head)
      evict_oldest();
    owner_of[ring_tail] = g.id;
    row_of[ring_tail]   = pack_y + 1;
    r.kind  = KIND_PLACE;
    r.slot  = SLOT_IDX_W'(ring_tail);
    r.glyph = g.id;
    r.pos_x = POS_W'(pack_x + 1);
    r.pos_y = POS_W'(pack_y + 1);
    r.last  = 1'b1;
    pending_results.push_back(r);
    pack_x   += w + GLYPH_PAD;
    ring_tail = (ring_tail + 1) % NUM_SLOTS;
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of items with random gaps, fed from glyph_queue.
  // ---------------------------------------------------------------------------
  glyph_req_t glyph_queue [$];
  glyph_req_t on_bus;
  int         burst_left, gap_left;
  logic       offer;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left     = $urandom_range(1, 30);
      gap_left       = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        place_glyph(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (glyph_queue.size() > 0 &&
                     !(glyph_queue[0].hold && pending_results.size() > 0)) begin
          on_bus = glyph_queue.pop_front();
          offer  = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0;
          end
        end
        s_axis_tvalid <= offer;
        if (offer) begin
          s_axis_tdata <= {on_bus.height, on_bus.width, on_bus.id};
          s_axis_tuser <= on_bus.resident;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted item against the oldest expectation,
  // and drives tready from a pattern that changes mode every so often.
  // ---------------------------------------------------------------------------
  sink_mode_t    sink_mode;
  int            sink_left;
  logic          sink_ready;
  atlas_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_mode      = RX_FREE;
      sink_left      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("ERROR at %0t: unexpected result item, tdata 0x%0h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser[0] !== want.kind)
            report_mismatch("kind", m_axis_tuser[0], want.kind);
          if (m_axis_tdata[5:0] !== want.slot)
            report_mismatch("slot_index", m_axis_tdata[5:0], want.slot);
          if (m_axis_tdata[21:6] !== want.glyph)
            report_mismatch("slot_glyph", m_axis_tdata[21:6], want.glyph);
          if (m_axis_tdata[30:22] !== want.pos_x)
            report_mismatch("pos_x", m_axis_tdata[30:22], want.pos_x);
          if (m_axis_tdata[39:31] !== want.pos_y)
            report_mismatch("pos_y", m_axis_tdata[39:31], want.pos_y);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
      end
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(16, 200);
      end else begin
        sink_left--;
      end
      case (sink_mode)
        RX_FREE:   sink_ready = 1'b1;
        RX_COIN:   sink_ready = $urandom_range(0, 1);
        RX_SPARSE: sink_ready = (sink_left % 4 == 0);
        default:   sink_ready = (sink_left % 8 < 3);   // stalls of five
      endcase
      m_axis_tready <= sink_ready;
    end
  end

  // Watchdog: too long with nothing moving on either side.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  task automatic queue_glyph(int unsigned id, int unsigned w, int unsigned h,
                             bit resident, bit hold);
    glyph_req_t g;
    g.id       = ID_W'(id);
    g.width    = DIM_W'(w);
    g.height   = DIM_W'(h);
    g.resident = resident;
    g.hold     = hold;
    glyph_queue.push_back(g);
  endtask

  initial begin
    int run_kind, run_len, placed, max_dim;
    bit resident;

    error_count = 0;
    pack_x      = 0;
    pack_y      = 0;
    shelf_h     = 0;
    ring_head   = 0;
    ring_tail   = 0;

    // directed: smallest glyph, resident skip, largest glyph
    queue_glyph(16'h0000, 0, 0, 1'b0, 1'b0);
    queue_glyph(16'hFFFF, 255, 255, 1'b1, 1'b0);
    queue_glyph(16'hFFFF, 255, 255, 1'b0, 1'b0);
    // row filled exactly to the right edge, then a row wrap
    queue_glyph(16'hAAAA, 251, 0, 1'b0, 1'b0);
    queue_glyph(16'h5555, 0, 0, 1'b0, 1'b0);
    // shelf reaching exactly to the bottom edge, then a top wrap
    queue_glyph(16'h1234, 10, 253, 1'b0, 1'b0);
    queue_glyph(16'h8001, 255, 255, 1'b0, 1'b0);
    queue_glyph(16'h0000, 0, 0, 1'b1, 1'b0);
    // row wrap under a tall shelf, then a second top wrap after a drain
    queue_glyph(16'h7FFF, 255, 1, 1'b0, 1'b0);
    queue_glyph(16'h00FF, 0, 255, 1'b0, 1'b1);
    for (int i = 0; i < 10; i++)
      queue_glyph(16'h0101 << i, i, 9 - i, 1'b0, 1'b0);
    queue_glyph(16'hFF00, 128, 128, 1'b0, 1'b0);

    // random runs: long runs of small glyphs fill the ring, mixed runs and
    // large glyphs drive the row and top wraps
    placed = 0;
    while (placed < RANDOM_GLYPHS) begin
      run_kind = $urandom_range(0, 9);
      if (run_kind < 4) begin
        run_len = $urandom_range(40, 80);
        max_dim = 6;
      end else if (run_kind < 8) begin
        run_len = $urandom_range(5, 20);
        max_dim = 80;
      end else begin
        run_len = $urandom_range(2, 6);
        max_dim = 255;
      end
      for (int i = 0; i < run_len && placed < RANDOM_GLYPHS; i++) begin
        resident = ($urandom_range(0, 11) == 0);
        queue_glyph($urandom_range(0, 65535), $urandom_range(0, max_dim),
                    $urandom_range(0, max_dim), resident,
                    i == 0 && (placed == 0 || $urandom_range(0, 2) == 0));
        placed++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (glyph_queue.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    while (pending_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
